/* hdl/atern_pkg.sv */
// Package for the adaptive threshold ternarizer: widths, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package atern_pkg;
  localparam int MaxItems   = 64;
  localparam int SampleBits = 16;
  localparam int IdxBits    = $clog2(MaxItems);
  localparam int CntBits    = $clog2(MaxItems + 1);
  localparam int MagBits    = SampleBits + 1;
  localparam int SumBits    = MagBits + IdxBits;
  localparam int CfgIdxBits = 1;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegRuleSelect   = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegZeroFraction = 1'b1;

  localparam logic [1:0] TritZero = 2'b00;
  localparam logic [1:0] TritPos  = 2'b01;
  localparam logic [1:0] TritNeg  = 2'b11;

  // Controller to datapath commands.
  typedef struct packed {
    logic store;      // write accepted sample, accumulate magnitude
    logic clear;      // clear count and sum
    logic div_start;  // load mean divider
    logic div_step;   // one restoring division step
    logic rank_start; // start counting for candidate i
    logic rank_step;  // compare candidate with entry j
    logic rank_take;  // capture candidate as threshold
    logic mean_take;  // capture quotient as threshold
    logic emit_load;  // register output of entry j
  } atern_cmd_t;

  typedef struct packed {
    logic [CntBits-1:0] count;
    logic               rank_hit; // candidate is the k-th smallest
  } atern_stat_t;

  function automatic logic [MagBits-1:0] mag_of(input logic [SampleBits-1:0] raw);
    if (raw[SampleBits-1]) begin
      return MagBits'((MagBits)'(1) << SampleBits) - {1'b0, raw};
    end
    return {1'b0, raw};
  endfunction
endpackage
`default_nettype wire

/* hdl/atern_if.sv */
// Valid/ready channel interfaces for samples, trits and configuration writes.
// Depends on atern_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface atern_in_if import atern_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample;
  logic                  end_of_vector;
  modport source (output valid, sample, end_of_vector, input ready);
  modport sink (input valid, sample, end_of_vector, output ready);
endinterface

interface atern_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  trit;
  logic [15:0] threshold;
  logic        final_trit;
  modport source (output valid, trit, threshold, final_trit, input ready);
  modport sink (input valid, trit, threshold, final_trit, output ready);
endinterface

interface atern_cfg_if import atern_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/adaptive_threshold_ternarizer_core.sv */
// Top level of the adaptive threshold ternarizer: config registers, controller, datapath.
// Depends on atern_pkg, atern_if, atern_ctrl, atern_datapath.
// Samples load one per cycle until end_of_vector or the 64th sample. Then a
// threshold is found: mean rule by a restoring divider (load, 23 quotient
// steps, capture); quantile rule by a rank search that, for each candidate i
// in turn, counts entries smaller and not larger, stopping at the first
// candidate whose rank brackets k.
// Each trit then passes through memory address, registered read and output
// states; the read state waits while the output register is still full.
// The block takes no sample between end of load and the loading of the final
// trit into the output register, which holds each trit until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_threshold_ternarizer_core import atern_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  atern_in_if.sink    in_ch,
  atern_out_if.source out_ch,
  atern_cfg_if.sink   cfg
);
  logic              rule_select;
  logic [15:0]       zero_fraction;
  atern_cmd_t        cmd;
  atern_stat_t       stat;
  logic [IdxBits-1:0] ci, cj;
  logic              emit_last;

  // Config writes are always taken; an unknown index is dropped.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_select   <= 1'b0;
      zero_fraction <= 16'd13107;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegRuleSelect:   rule_select   <= cfg.data[0];
        RegZeroFraction: zero_fraction <= cfg.data;
        default: ;
      endcase
    end
  end

  atern_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_last  (in_ch.end_of_vector),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .rule_select,
    .stat, .cmd, .ci, .cj, .emit_last
  );

  atern_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_sample (in_ch.sample),
    .zero_fraction,
    .ci, .cj, .emit_last,
    .trit      (out_ch.trit),
    .threshold (out_ch.threshold),
    .final_trit(out_ch.final_trit)
  );
endmodule
`default_nettype wire

/* hdl/atern_datapath.sv */
// Datapath: sample memory, magnitude sum, mean divider, rank counter, output register.
// Depends on atern_pkg.
`timescale 1ns / 1ps
`default_nettype none
module atern_datapath import atern_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire atern_cmd_t            cmd,
  output atern_stat_t                stat,
  input  wire logic [SampleBits-1:0] in_sample,
  input  wire logic [15:0]           zero_fraction,
  input  wire logic [IdxBits-1:0]    ci,
  input  wire logic [IdxBits-1:0]    cj,
  input  wire logic                  emit_last,
  output logic [1:0]                 trit,
  output logic [15:0]                threshold,
  output logic                       final_trit
);
  logic [SampleBits-1:0] mem [MaxItems];
  logic [SampleBits-1:0] rd_j;
  logic [SampleBits-1:0] rd_i;
  logic [CntBits-1:0]    count;
  logic [SumBits-1:0]    sum;
  logic [SumBits-1:0]    rem;
  logic [SumBits-1:0]    quo;
  logic [MagBits-1:0]    thr;
  logic [CntBits-1:0]    less_cnt;
  logic [CntBits-1:0]    leq_cnt;
  logic [CntBits+15:0]   kprod;
  logic [CntBits-1:0]    k;
  logic [MagBits-1:0]    mag_i;
  logic [MagBits-1:0]    mag_j;
  logic [SumBits:0]      trial;

  // Memory reads are registered; the controller uses read data no earlier than the cycle after addressing.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[IdxBits-1:0]] <= in_sample;
    end
    rd_j <= mem[cj];
    rd_i <= mem[ci];
  end

  assign mag_i = mag_of(rd_i);
  assign mag_j = mag_of(rd_j);
  assign kprod = CntBits'(count) * zero_fraction;
  always_comb begin
    k = kprod[CntBits+15:16];
    if (k >= count) begin
      k = count - CntBits'(1);
    end
  end
  assign trial = {rem, quo[SumBits-1]} - (SumBits + 1)'(count);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      sum   <= '0;
    end else if (cmd.store) begin
      count <= count + CntBits'(1);
      sum   <= sum + SumBits'(mag_of(in_sample));
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= sum;
    end else if (cmd.div_step) begin
      if (!trial[SumBits]) begin
        rem <= trial[SumBits-1:0];
        quo <= {quo[SumBits-2:0], 1'b1};
      end else begin
        rem <= {rem[SumBits-2:0], quo[SumBits-1]};
        quo <= {quo[SumBits-2:0], 1'b0};
      end
    end
    if (cmd.rank_start) begin
      less_cnt <= '0;
      leq_cnt  <= '0;
    end else if (cmd.rank_step) begin
      if (mag_j < mag_i) less_cnt <= less_cnt + CntBits'(1);
      if (mag_j <= mag_i) leq_cnt <= leq_cnt + CntBits'(1);
    end
    if (cmd.rank_take) begin
      thr <= mag_i;
    end else if (cmd.mean_take) begin
      thr <= quo[MagBits-1:0];
    end
    if (cmd.emit_load) begin
      threshold  <= thr[15:0];
      final_trit <= emit_last;
      if (mag_j <= thr) trit <= TritZero;
      else if (rd_j[SampleBits-1]) trit <= TritNeg;
      else trit <= TritPos;
    end
  end

  // The k-th smallest is any value with less < k+1 and leq > k.
  assign stat.count    = count;
  assign stat.rank_hit = (less_cnt <= k) && (leq_cnt > k);
endmodule
`default_nettype wire

/* hdl/atern_ctrl.sv */
// Controller state machine: load, threshold search, emit with output register.
// Depends on atern_pkg.
`timescale 1ns / 1ps
`default_nettype none
module atern_ctrl import atern_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire logic               rule_select,
  input  wire atern_stat_t        stat,
  output atern_cmd_t              cmd,
  output logic [IdxBits-1:0]      ci,
  output logic [IdxBits-1:0]      cj,
  output logic                    emit_last
);
  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_RSET  = 8'b0000_0100,
    S_RRUN  = 8'b0000_1000,
    S_RCHK  = 8'b0001_0000,
    S_EADDR = 8'b0010_0000,
    S_EREAD = 8'b0100_0000,
    S_EOUT  = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [CntBits-1:0]  i, j;
  logic [CntBits-1:0]  i_next, j_next;
  logic                out_valid_next;
  logic [CntBits-1:0]  last_idx;
  logic                full;

  assign ci = i[IdxBits-1:0];
  assign cj = j[IdxBits-1:0];
  assign last_idx = stat.count - CntBits'(1);
  assign full = stat.count == CntBits'(MaxItems - 1);
  assign in_ready = state == S_LOAD;
  assign emit_last = j == last_idx;

  always_comb begin
    state_next = state;
    i_next = i;
    j_next = j;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          i_next = '0;
          j_next = '0;
          if (in_last || full) begin
            if (rule_select) begin
              state_next = S_DIV;
            end else begin
              state_next = S_RSET;
            end
          end
        end
      end
      S_DIV: begin
        // load the divider once the last sum is in, then one step per quotient bit
        j_next = j + CntBits'(1);
        if (j == '0) begin
          cmd.div_start = 1'b1;
        end else if (j == CntBits'(SumBits + 1)) begin
          cmd.mean_take = 1'b1;
          j_next = '0;
          state_next = S_EADDR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RSET: begin
        // address candidate i and clear j; candidate data valid next cycle
        cmd.rank_start = 1'b1;
        j_next = '0;
        state_next = S_RRUN;
      end
      S_RRUN: begin
        // rd_j tracks entry j-1 addressed last cycle; step counts it
        if (j != '0) cmd.rank_step = 1'b1;
        if (j == stat.count) begin
          state_next = S_RCHK;
        end else begin
          j_next = j + CntBits'(1);
        end
      end
      S_RCHK: begin
        if (stat.rank_hit) begin
          cmd.rank_take = 1'b1;
          j_next = '0;
          state_next = S_EADDR;
        end else begin
          i_next = i + CntBits'(1);
          state_next = S_RSET;
        end
      end
      S_EADDR: state_next = S_EREAD;
      S_EREAD: begin
        if (!out_valid || out_ready) begin
          cmd.emit_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_EOUT;
        end
      end
      S_EOUT: begin
        if (emit_last) begin
          cmd.clear = 1'b1;
          state_next = S_LOAD;
        end else begin
          j_next = j + CntBits'(1);
          state_next = S_EADDR;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      out_valid <= 1'b0;
      i <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      i <= i_next;
      j <= j_next;
    end
  end
endmodule
`default_nettype wire
